// ----- rtl/rwc_pkg.sv -----
// Shared types and constants of the RGB window convolution block.
package rwc_pkg;

   localparam int BYTE_W     = 8;
   localparam int CHAN_NUM   = 3;
   localparam int PIX_W      = BYTE_W * CHAN_NUM;
   localparam int COEF_W     = 16;
   localparam int COEF_IDX_W = 5;
   localparam int PROD_W     = COEF_W + BYTE_W;
   localparam int IMG_W_W    = 11;
   localparam int IMG_H_W    = 13;
   localparam int DIM_W      = 3;
   localparam int ROW_W      = 12;
   localparam int OUT_COL_W  = 10;
   localparam int MAX_HEIGHT = 4096;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd1024;
   localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd768;
   localparam logic [DIM_W-1:0]   KERNEL_DIM_RST   = 3'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_KERNEL_DIM   = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_COEF  = 1'b0,
      REQ_PIXEL = 1'b1
   } req_kind_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // line memory access controls
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } line_ctl_type;

   // load strobes of the arithmetic stages
   typedef struct packed {
      logic prod_load;
      logic row_load;
      logic out_load;
   } mac_ctl_type;

   // position and framing of a result traveling down the pipe
   typedef struct packed {
      logic [ROW_W-1:0]     out_row;
      logic [OUT_COL_W-1:0] out_col;
      logic                 frame_last;
   } meta_type;

endpackage

// ----- rtl/rwc_line_buffer.sv -----
// Line memory holding the previous rows of each column, with read-after-write bypass.
module rwc_line_buffer #(
   parameter int MAX_DIM   = 5,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                         clock,
   input  rwc_pkg::line_ctl_type                        ctl,
   input  logic [$clog2(MAX_WIDTH)-1:0]                 rd_addr,
   input  logic [$clog2(MAX_WIDTH)-1:0]                 wr_addr,
   input  logic [rwc_pkg::PIX_W-1:0]                    cur_pixel,
   output logic [MAX_DIM-1:0][rwc_pkg::PIX_W-1:0]       col_vec
);
   import rwc_pkg::*;

   localparam int ADDR_W    = $clog2(MAX_WIDTH);
   localparam int LINE_ROWS = (MAX_DIM > 1) ? MAX_DIM - 1 : 1;

   logic [LINE_ROWS-1:0][PIX_W-1:0] line_mem_ff [MAX_WIDTH];
   logic [LINE_ROWS-1:0][PIX_W-1:0] rd_data_ff;
   logic [LINE_ROWS-1:0][PIX_W-1:0] fwd_data_ff;
   logic                            fwd_hit_ff;
   logic [LINE_ROWS-1:0][PIX_W-1:0] word_now;
   logic [LINE_ROWS-1:0][PIX_W-1:0] new_word;

   // take the word just written when it collided with this read
   always_comb begin
      word_now = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      new_word[0] = cur_pixel;
      for (int i = 1; i < LINE_ROWS; i++) begin
         new_word[i] = word_now[i-1];
      end
      col_vec[0] = cur_pixel;
      for (int i = 1; i < MAX_DIM; i++) begin
         col_vec[i] = word_now[i-1];
      end
   end

   // age the column by one row on write; read on request accept
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         line_mem_ff[wr_addr] <= new_word;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= line_mem_ff[rd_addr];
         fwd_hit_ff  <= ctl.wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= new_word;
      end
   end

endmodule

// ----- rtl/rwc_coef_bank.sv -----
// Kernel coefficient store and per-tap coefficient selection for the active kernel size.
module rwc_coef_bank #(
   parameter int MAX_DIM = 5
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                wr_en,
   input  logic [rwc_pkg::COEF_IDX_W-1:0]                      wr_index,
   input  logic [rwc_pkg::COEF_W-1:0]                          wr_value,
   input  logic [rwc_pkg::DIM_W-1:0]                           dim_eff,
   output logic [MAX_DIM-1:0][MAX_DIM-1:0][rwc_pkg::COEF_W-1:0] tap_coef
);
   import rwc_pkg::*;

   localparam int NTAP      = MAX_DIM * MAX_DIM;
   localparam int TAP_IDX_W = (NTAP > 1) ? $clog2(NTAP) : 1;

   logic [COEF_W-1:0] coef_ff [NTAP];
   logic [MAX_DIM-1:0][MAX_DIM-1:0][COEF_W-1:0] tap_coef_ff;
   logic [MAX_DIM-1:0][MAX_DIM-1:0][COEF_W-1:0] tap_coef_in;
   logic [TAP_IDX_W-1:0] wr_slot;

   assign wr_slot  = TAP_IDX_W'(wr_index);
   assign tap_coef = tap_coef_ff;

   // store coefficients by flat index; drop indexes past the store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NTAP; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (wr_en && (32'(wr_index) < NTAP)) begin
         coef_ff[wr_slot] <= wr_value;
      end
   end

   // map each window tap (row age a, column age b) to its flat coefficient
   always_comb begin
      for (int a = 0; a < MAX_DIM; a++) begin
         for (int b = 0; b < MAX_DIM; b++) begin
            tap_coef_in[a][b] = '0;
            for (int dd = 1; dd <= MAX_DIM; dd++) begin
               if ((32'(dim_eff) == dd) && (a < dd) && (b < dd)) begin
                  tap_coef_in[a][b] = coef_ff[(dd - 1 - a) * dd + (dd - 1 - b)];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      tap_coef_ff <= tap_coef_in;
   end

endmodule

// ----- rtl/rwc_conv_datapath.sv -----
// Multiply, row-sum, total and clamp stages of the window convolution.
module rwc_conv_datapath #(
   parameter int MAX_DIM = 5
) (
   input  logic                                                 clock,
   input  rwc_pkg::mac_ctl_type                                 ctl,
   input  logic [MAX_DIM-1:0][MAX_DIM-1:0][rwc_pkg::PIX_W-1:0]  window,
   input  logic [MAX_DIM-1:0][MAX_DIM-1:0][rwc_pkg::COEF_W-1:0] tap_coef,
   output logic [rwc_pkg::BYTE_W-1:0]                           res0,
   output logic [rwc_pkg::BYTE_W-1:0]                           res1,
   output logic [rwc_pkg::BYTE_W-1:0]                           res2
);
   import rwc_pkg::*;

   localparam int ROW_SUM_W = PROD_W + $clog2(MAX_DIM);
   localparam int TOT_W     = ROW_SUM_W + $clog2(MAX_DIM);

   logic signed [PROD_W-1:0]    prod_ff    [MAX_DIM][MAX_DIM][CHAN_NUM];
   logic signed [PROD_W-1:0]    prod_in    [MAX_DIM][MAX_DIM][CHAN_NUM];
   logic signed [ROW_SUM_W-1:0] row_sum_ff [MAX_DIM][CHAN_NUM];
   logic signed [ROW_SUM_W-1:0] row_sum_in [MAX_DIM][CHAN_NUM];
   logic [BYTE_W-1:0]           res_ff     [CHAN_NUM];
   logic [BYTE_W-1:0]           res_in     [CHAN_NUM];

   // one product per tap and channel
   always_comb begin
      logic signed [PROD_W-1:0] cf_x;
      logic signed [PROD_W-1:0] px_x;
      for (int a = 0; a < MAX_DIM; a++) begin
         for (int b = 0; b < MAX_DIM; b++) begin
            for (int k = 0; k < CHAN_NUM; k++) begin
               cf_x = PROD_W'($signed(tap_coef[a][b]));
               px_x = $signed({{(PROD_W - BYTE_W){1'b0}},
                               window[a][b][k*BYTE_W +: BYTE_W]});
               prod_in[a][b][k] = cf_x * px_x;
            end
         end
      end
   end

   // sum each window row
   always_comb begin
      logic signed [ROW_SUM_W-1:0] acc;
      for (int a = 0; a < MAX_DIM; a++) begin
         for (int k = 0; k < CHAN_NUM; k++) begin
            acc = '0;
            for (int b = 0; b < MAX_DIM; b++) begin
               acc = acc + ROW_SUM_W'(prod_ff[a][b][k]);
            end
            row_sum_in[a][k] = acc;
         end
      end
   end

   // total the rows and clamp to a byte
   always_comb begin
      logic signed [TOT_W-1:0] total;
      for (int k = 0; k < CHAN_NUM; k++) begin
         total = '0;
         for (int a = 0; a < MAX_DIM; a++) begin
            total = total + TOT_W'(row_sum_ff[a][k]);
         end
         if (total[TOT_W-1]) begin
            res_in[k] = '0;
         end else if (|total[TOT_W-2:BYTE_W]) begin
            res_in[k] = '1;
         end else begin
            res_in[k] = total[BYTE_W-1:0];
         end
      end
   end

   // advance each stage on its load strobe
   always_ff @(posedge clock) begin
      if (ctl.prod_load) begin
         prod_ff <= prod_in;
      end
      if (ctl.row_load) begin
         row_sum_ff <= row_sum_in;
      end
      if (ctl.out_load) begin
         res_ff <= res_in;
      end
   end

   assign res0 = res_ff[0];
   assign res1 = res_ff[1];
   assign res2 = res_ff[2];

endmodule

// ----- rtl/rgb_window_convolution.sv -----
// RGB window convolution: raster pixels in, clamped convolution of each full window out.
// A result passes the input, window, product, row-sum and output registers in that order.
// Throughput: one request (pixel or coefficient) per cycle while the pipe is not stalled;
// the line memory reads and writes once per pixel; the five-stage pipe stalls per stage.
// Reset: synchronous; restores width 1024, height 768, kernel 3, zero coefficients and
// raster position; the line memory keeps its contents and holds no valid state.
module rgb_window_convolution #(
   parameter int MAX_DIM   = 5,
   parameter int MAX_WIDTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_write_en,
   input  logic [rwc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rwc_pkg::CSR_DATA_W-1:0]    csr_data,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_type,
   input  logic [rwc_pkg::COEF_IDX_W-1:0]    req_coef_index,
   input  logic [rwc_pkg::COEF_W-1:0]        req_coef_value,
   input  logic [rwc_pkg::BYTE_W-1:0]        req_chan0,
   input  logic [rwc_pkg::BYTE_W-1:0]        req_chan1,
   input  logic [rwc_pkg::BYTE_W-1:0]        req_chan2,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [rwc_pkg::ROW_W-1:0]         rsp_out_row,
   output logic [rwc_pkg::OUT_COL_W-1:0]     rsp_out_col,
   output logic [rwc_pkg::BYTE_W-1:0]        rsp_res0,
   output logic [rwc_pkg::BYTE_W-1:0]        rsp_res1,
   output logic [rwc_pkg::BYTE_W-1:0]        rsp_res2,
   output logic                              rsp_frame_last
);
   import rwc_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   // configuration
   logic [IMG_W_W-1:0] image_width_ff;
   logic [IMG_H_W-1:0] image_height_ff;
   logic [DIM_W-1:0]   kernel_dim_ff;
   logic [COL_W:0]     w_eff;
   logic [IMG_H_W-1:0] h_eff;
   logic [DIM_W-1:0]   d_eff;
   logic               csr_hit;

   // raster position
   logic [ROW_W-1:0]   row_count_ff;
   logic [ROW_W-1:0]   row_count_in;
   logic [COL_W-1:0]   col_count_ff;
   logic [COL_W-1:0]   col_count_in;
   logic [ROW_W-1:0]   cur_r;
   logic [COL_W-1:0]   cur_c;
   logic [IMG_H_W-1:0] r1;
   logic [COL_W:0]     c1;
   logic               emit;
   meta_type           meta_in;

   // handshake
   logic accept;
   logic pix_accept;
   logic rdy1;
   logic rdy2;
   logic rdy3;
   logic rdy4;
   logic rdy5;

   // stage 1: input register
   logic                  s1_valid_ff;
   logic                  s1_is_pix_ff;
   logic                  s1_emit_ff;
   meta_type              s1_meta_ff;
   pixel_type             s1_pixel_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic [COEF_IDX_W-1:0] s1_coef_idx_ff;
   logic [COEF_W-1:0]     s1_coef_val_ff;
   logic                  s1_adv;

   // stage 2: window
   logic                                       s2_valid_ff;
   meta_type                                   s2_meta_ff;
   logic [MAX_DIM-1:0][MAX_DIM-1:0][PIX_W-1:0] window_ff;
   logic [MAX_DIM-1:0][PIX_W-1:0]              col_vec;

   // stages 3 to 5
   logic     s3_valid_ff;
   meta_type s3_meta_ff;
   logic     s4_valid_ff;
   meta_type s4_meta_ff;
   logic     rsp_valid_ff;
   meta_type rsp_meta_ff;

   logic [MAX_DIM-1:0][MAX_DIM-1:0][COEF_W-1:0] tap_coef;
   line_ctl_type line_ctl;
   mac_ctl_type  mac_ctl;

   // clamp configuration to its usable range
   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = (COL_W+1)'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         w_eff = (COL_W+1)'(MAX_WIDTH);
      end else begin
         w_eff = (COL_W+1)'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         h_eff = IMG_H_W'(1);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         h_eff = IMG_H_W'(MAX_HEIGHT);
      end else begin
         h_eff = image_height_ff;
      end
      if (kernel_dim_ff == '0) begin
         d_eff = DIM_W'(1);
      end else if (32'(kernel_dim_ff) > MAX_DIM) begin
         d_eff = DIM_W'(MAX_DIM);
      end else begin
         d_eff = kernel_dim_ff;
      end
   end

   assign csr_hit = csr_write_en && ((csr_index == CSR_IMAGE_WIDTH) ||
                                     (csr_index == CSR_IMAGE_HEIGHT) ||
                                     (csr_index == CSR_KERNEL_DIM));

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
         kernel_dim_ff   <= KERNEL_DIM_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_data[IMG_H_W-1:0];
            CSR_KERNEL_DIM:   kernel_dim_ff   <= csr_data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // position of this pixel, window origin and next position
   always_comb begin
      cur_r = (IMG_H_W'(row_count_ff) >= h_eff) ? '0 : row_count_ff;
      cur_c = ((COL_W+1)'(col_count_ff) >= w_eff) ? '0 : col_count_ff;
      r1    = IMG_H_W'(cur_r) + IMG_H_W'(1);
      c1    = (COL_W+1)'(cur_c) + (COL_W+1)'(1);
      emit  = (r1 >= IMG_H_W'(d_eff)) && (c1 >= (COL_W+1)'(d_eff));
      meta_in.out_row    = ROW_W'(r1 - IMG_H_W'(d_eff));
      meta_in.out_col    = OUT_COL_W'(c1 - (COL_W+1)'(d_eff));
      meta_in.frame_last = (r1 == h_eff) && (c1 == w_eff);
      if (c1 >= w_eff) begin
         col_count_in = '0;
         row_count_in = (r1 >= h_eff) ? '0 : ROW_W'(r1);
      end else begin
         col_count_in = COL_W'(c1);
         row_count_in = cur_r;
      end
   end

   // stall chain: a stage takes new data when empty or when it moves on
   assign rdy5      = !rsp_valid_ff || !rsp_stall;
   assign rdy4      = !s4_valid_ff || rdy5;
   assign rdy3      = !s3_valid_ff || rdy4;
   assign rdy2      = !s2_valid_ff || rdy3;
   assign rdy1      = !s1_valid_ff || rdy2;
   assign req_stall = !rdy1;

   assign accept     = req_valid && rdy1;
   assign pix_accept = accept && (req_type == REQ_PIXEL);
   assign s1_adv     = s1_valid_ff && rdy2;

   // advance raster position; restart the frame on configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
      end else if (csr_hit) begin
         row_count_ff <= '0;
         col_count_ff <= '0;
      end else if (pix_accept) begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // stage 1: capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (rdy1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_is_pix_ff   <= (req_type == REQ_PIXEL);
         s1_emit_ff     <= emit;
         s1_meta_ff     <= meta_in;
         s1_pixel_ff    <= {req_chan2, req_chan1, req_chan0};
         s1_col_ff      <= cur_c;
         s1_coef_idx_ff <= req_coef_index;
         s1_coef_val_ff <= req_coef_value;
      end
   end

   // line memory: read on pixel accept, write back as the pixel leaves stage 1
   assign line_ctl.rd_en = pix_accept;
   assign line_ctl.wr_en = s1_adv && s1_is_pix_ff;

   rwc_line_buffer #(
      .MAX_DIM   (MAX_DIM),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buffer (
      .clock     (clock),
      .ctl       (line_ctl),
      .rd_addr   (cur_c),
      .wr_addr   (s1_col_ff),
      .cur_pixel (s1_pixel_ff),
      .col_vec   (col_vec)
   );

   // coefficient loads take effect as they leave stage 1, in request order
   rwc_coef_bank #(
      .MAX_DIM (MAX_DIM)
   ) u_coef_bank (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (s1_adv && !s1_is_pix_ff),
      .wr_index (s1_coef_idx_ff),
      .wr_value (s1_coef_val_ff),
      .dim_eff  (d_eff),
      .tap_coef (tap_coef)
   );

   // stage 2: shift the new column into the window
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (rdy2) begin
         s2_valid_ff <= s1_valid_ff && s1_is_pix_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_meta_ff <= s1_meta_ff;
      end
      if (line_ctl.wr_en) begin
         for (int a = 0; a < MAX_DIM; a++) begin
            window_ff[a][0] <= col_vec[a];
            for (int b = 1; b < MAX_DIM; b++) begin
               window_ff[a][b] <= window_ff[a][b-1];
            end
         end
      end
   end

   // stages 3 to 5: products, row sums, output register
   assign mac_ctl.prod_load = rdy3;
   assign mac_ctl.row_load  = rdy4;
   assign mac_ctl.out_load  = rdy5;

   rwc_conv_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_conv_datapath (
      .clock    (clock),
      .ctl      (mac_ctl),
      .window   (window_ff),
      .tap_coef (tap_coef),
      .res0     (rsp_res0),
      .res1     (rsp_res1),
      .res2     (rsp_res2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (rdy4) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (rdy5) begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_meta_ff <= s2_meta_ff;
      end
      if (rdy4) begin
         s4_meta_ff <= s3_meta_ff;
      end
      if (rdy5) begin
         rsp_meta_ff <= s4_meta_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_row    = rsp_meta_ff.out_row;
   assign rsp_out_col    = rsp_meta_ff.out_col;
   assign rsp_frame_last = rsp_meta_ff.frame_last;

endmodule
